[hw/rtl/smh_pkg.sv]
package smh_pkg;

    // Register file holding the working words of the hash
    localparam int RF_DEPTH = 11;
    localparam int RF_AW    = $clog2(RF_DEPTH);
    typedef logic [RF_AW-1:0] reg_idx_t;

    localparam reg_idx_t REG_A = reg_idx_t'(0);
    localparam reg_idx_t REG_B = reg_idx_t'(1);
    localparam reg_idx_t REG_C = reg_idx_t'(2);
    localparam reg_idx_t REG_D = reg_idx_t'(3);
    localparam reg_idx_t REG_E = reg_idx_t'(4);
    localparam reg_idx_t REG_F = reg_idx_t'(5);
    localparam reg_idx_t REG_G = reg_idx_t'(6);
    localparam reg_idx_t REG_H = reg_idx_t'(7);
    localparam reg_idx_t REG_X = reg_idx_t'(8);   // running word
    localparam reg_idx_t REG_T = reg_idx_t'(9);   // scratch
    localparam reg_idx_t REG_U = reg_idx_t'(10);  // first hash word

    // Micro program counter
    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t ABSORB_PC = upc_t'(0);
    localparam upc_t EMIT_PC   = upc_t'(33);
    localparam upc_t END_PC    = upc_t'(50);
    localparam upc_t START_PC  = upc_t'(51);

    typedef enum logic [3:0] {
        UOP_ADD,    // wa = ra + rb
        UOP_XOR,    // wa = ra ^ rb
        UOP_CHUNK,  // wa = ra + chunk, byte count steps down
        UOP_MUL,    // wa = ra * operand b
        UOP_MULK,   // wa = seed constant of wa * length
        UOP_BNZ,    // jump to target while bytes remain
        UOP_JMP,    // jump to target
        UOP_EMIT,   // result = {ra, rb}
        UOP_END     // back to idle
    } uop_t;

    typedef enum logic [1:0] {
        BSEL_REG,
        BSEL_POP,
        BSEL_REM,
        BSEL_LEN
    } bsel_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_XOR,
        ALU_CHUNK
    } alu_t;

    typedef enum logic {
        WSRC_ALU,
        WSRC_MUL
    } wsrc_t;

    typedef struct packed {
        uop_t     op;
        reg_idx_t wa;
        reg_idx_t ra;
        reg_idx_t rb;
        bsel_t    bsel;
        upc_t     target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic     we;
        wsrc_t    wsrc;
        alu_t     alu;
        reg_idx_t wa;
        reg_idx_t ra;
        reg_idx_t rb;
        logic     mul_start;
        logic     mul_k;
        bsel_t    bsel;
        logic     emit;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic rem_nz;
        logic mul_done;
        logic out_stall;
    } status_t;

    // Item launch from the input channel
    typedef struct packed {
        logic        start;
        logic        absorb;
        logic [31:0] length;
        logic [63:0] word;
    } load_t;

    typedef struct packed {
        logic        start_req;
        logic [31:0] message_length;
        logic [63:0] message_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] hash_first;
        logic [63:0] hash_second;
    } out_item_t;

    // Seed constants, one per working register
    function automatic logic [63:0] k_const(reg_idx_t idx);
        logic [63:0] k;
        case (idx)
            REG_A:   k = 64'h5555555555555555;
            REG_B:   k = 64'hD0BE70F475039C26;
            REG_C:   k = 64'h0A28494D0470FBCF;
            REG_D:   k = 64'h2269E48CA777A798;
            REG_E:   k = 64'hAAAAAAAAAAAAAAAA;
            REG_F:   k = 64'hE697EB07151FA162;
            REG_G:   k = 64'h7ED6D2C445D9F5F6;
            REG_H:   k = 64'h47DF9C8E1A35F1BA;
            REG_X:   k = 64'h66A89CDDE262DA8D;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic uword_t uw(uop_t op, reg_idx_t wa, reg_idx_t ra, reg_idx_t rb,
                                  bsel_t bsel, upc_t target);
        uword_t w;
        w.op     = op;
        w.wa     = wa;
        w.ra     = ra;
        w.rb     = rb;
        w.bsel   = bsel;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t alu3(uop_t op, reg_idx_t wa, reg_idx_t ra, reg_idx_t rb);
        return uw(op, wa, ra, rb, BSEL_REG, ABSORB_PC);
    endfunction

    // Control store
    function automatic uword_t ucode(upc_t pc);
        uword_t w;
        case (pc)
            // chunk absorb
            6'd0:  w = alu3(UOP_CHUNK, REG_X, REG_X, REG_X);
            6'd1:  w = uw(UOP_MUL, REG_T, REG_X, REG_X, BSEL_POP, ABSORB_PC);
            6'd2:  w = alu3(UOP_ADD, REG_X, REG_X, REG_T);
            // first mix chain
            6'd3:  w = alu3(UOP_ADD, REG_A, REG_A, REG_X);
            6'd4:  w = alu3(UOP_XOR, REG_B, REG_B, REG_A);
            6'd5:  w = alu3(UOP_ADD, REG_C, REG_C, REG_B);
            6'd6:  w = alu3(UOP_XOR, REG_D, REG_D, REG_C);
            6'd7:  w = alu3(UOP_ADD, REG_X, REG_X, REG_D);
            6'd8:  w = alu3(UOP_XOR, REG_E, REG_E, REG_X);
            6'd9:  w = alu3(UOP_ADD, REG_F, REG_F, REG_E);
            6'd10: w = alu3(UOP_XOR, REG_G, REG_G, REG_F);
            6'd11: w = alu3(UOP_ADD, REG_H, REG_H, REG_G);
            // second mix chain
            6'd12: w = alu3(UOP_ADD, REG_C, REG_C, REG_X);
            6'd13: w = alu3(UOP_XOR, REG_G, REG_G, REG_C);
            6'd14: w = alu3(UOP_ADD, REG_E, REG_E, REG_G);
            6'd15: w = alu3(UOP_XOR, REG_A, REG_A, REG_E);
            6'd16: w = alu3(UOP_ADD, REG_X, REG_X, REG_A);
            6'd17: w = alu3(UOP_XOR, REG_B, REG_B, REG_X);
            6'd18: w = alu3(UOP_ADD, REG_D, REG_D, REG_B);
            6'd19: w = alu3(UOP_XOR, REG_H, REG_H, REG_D);
            6'd20: w = alu3(UOP_ADD, REG_F, REG_F, REG_H);
            // third mix chain
            6'd21: w = alu3(UOP_ADD, REG_H, REG_H, REG_X);
            6'd22: w = alu3(UOP_XOR, REG_G, REG_G, REG_H);
            6'd23: w = alu3(UOP_ADD, REG_F, REG_F, REG_G);
            6'd24: w = alu3(UOP_XOR, REG_E, REG_E, REG_F);
            6'd25: w = alu3(UOP_ADD, REG_X, REG_X, REG_E);
            6'd26: w = alu3(UOP_XOR, REG_D, REG_D, REG_X);
            6'd27: w = alu3(UOP_ADD, REG_C, REG_C, REG_D);
            6'd28: w = alu3(UOP_XOR, REG_B, REG_B, REG_C);
            6'd29: w = alu3(UOP_ADD, REG_A, REG_A, REG_B);
            // x += x * bytes remaining
            6'd30: w = uw(UOP_MUL, REG_T, REG_X, REG_X, BSEL_REM, ABSORB_PC);
            6'd31: w = alu3(UOP_ADD, REG_X, REG_X, REG_T);
            6'd32: w = uw(UOP_BNZ, REG_X, REG_X, REG_X, BSEL_REG, END_PC);
            // finals
            6'd33: w = alu3(UOP_MUL, REG_T, REG_X, REG_B);
            6'd34: w = alu3(UOP_ADD, REG_T, REG_T, REG_D);
            6'd35: w = alu3(UOP_MUL, REG_T, REG_T, REG_F);
            6'd36: w = alu3(UOP_ADD, REG_T, REG_T, REG_H);
            6'd37: w = alu3(UOP_MUL, REG_T, REG_T, REG_A);
            6'd38: w = alu3(UOP_ADD, REG_T, REG_T, REG_C);
            6'd39: w = alu3(UOP_MUL, REG_T, REG_T, REG_E);
            6'd40: w = alu3(UOP_ADD, REG_U, REG_T, REG_G);
            6'd41: w = alu3(UOP_MUL, REG_T, REG_X, REG_G);
            6'd42: w = alu3(UOP_ADD, REG_T, REG_T, REG_E);
            6'd43: w = alu3(UOP_MUL, REG_T, REG_T, REG_C);
            6'd44: w = alu3(UOP_ADD, REG_T, REG_T, REG_A);
            6'd45: w = alu3(UOP_MUL, REG_T, REG_T, REG_H);
            6'd46: w = alu3(UOP_ADD, REG_T, REG_T, REG_F);
            6'd47: w = alu3(UOP_MUL, REG_T, REG_T, REG_D);
            6'd48: w = alu3(UOP_ADD, REG_T, REG_T, REG_B);
            6'd49: w = alu3(UOP_EMIT, REG_U, REG_U, REG_T);
            6'd50: w = alu3(UOP_END, REG_X, REG_X, REG_X);
            // message start: seed all working words
            6'd51: w = uw(UOP_MULK, REG_A, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd52: w = uw(UOP_MULK, REG_B, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd53: w = uw(UOP_MULK, REG_C, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd54: w = uw(UOP_MULK, REG_D, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd55: w = uw(UOP_MULK, REG_E, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd56: w = uw(UOP_MULK, REG_F, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd57: w = uw(UOP_MULK, REG_G, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd58: w = uw(UOP_MULK, REG_H, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd59: w = uw(UOP_MULK, REG_X, REG_X, REG_X, BSEL_LEN, ABSORB_PC);
            6'd60: w = uw(UOP_BNZ, REG_X, REG_X, REG_X, BSEL_REG, END_PC);
            6'd61: w = uw(UOP_JMP, REG_X, REG_X, REG_X, BSEL_REG, EMIT_PC);
            default: w = alu3(UOP_END, REG_X, REG_X, REG_X);
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/smh_stream_if.sv]
interface smh_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/smh_ram.sv]
module smh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hw/rtl/smh_mul.sv]
module smh_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    // low 64 bits of a*b from three 32x32 partial products
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;

    // partial product operands per step
    always_comb
    begin
        op_x = a_reg[31:0];
        op_y = b_reg[31:0];
        case (cnt_reg)
            2'd1:    op_y = b_reg[63:32];
            2'd2:    op_x = a_reg[63:32];
            default: ;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands, product register and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
        begin
            prod_reg <= op_x * op_y;
            case (cnt_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2,
                2'd3:    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                default: ;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[hw/rtl/smh_datapath.sv]
module smh_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  smh_pkg::load_t   load,
    input  smh_pkg::ctrl_t   ctrl,
    output smh_pkg::status_t status,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [63:0]      hash_first,
    output logic [63:0]      hash_second
);

    logic [31:0] len_reg;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [63:0] chunk_reg;
    logic        out_valid_reg;
    logic [63:0] first_reg;
    logic [63:0] second_reg;
    logic [63:0] rd_a;
    logic [63:0] rd_b;
    logic [63:0] alu_res;
    logic [63:0] wdata;
    logic [63:0] chunk_sel;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] mul_product;
    logic [6:0]  pop;
    logic        mul_done;
    logic        ge8;

    smh_ram #(
        .WIDTH (64),
        .DEPTH (smh_pkg::RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (ctrl.we),
        .waddr   (ctrl.wa),
        .wdata   (wdata),
        .raddr_a (ctrl.ra),
        .raddr_b (ctrl.rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    smh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // chunk is the whole word while eight or more bytes remain
    assign ge8       = |rem_reg[31:3];
    assign chunk_sel = ge8 ? chunk_reg : {56'd0, chunk_reg[7:0]};
    assign rem_next  = ge8 ? rem_reg - 32'd8 : rem_reg - 32'd1;
    assign pop       = 7'($countones(rd_a));

    // add / xor unit
    always_comb
    begin
        case (ctrl.alu)
            smh_pkg::ALU_XOR:   alu_res = rd_a ^ rd_b;
            smh_pkg::ALU_CHUNK: alu_res = rd_a + chunk_sel;
            default:            alu_res = rd_a + rd_b;
        endcase
    end

    assign wdata = (ctrl.wsrc == smh_pkg::WSRC_MUL) ? mul_product : alu_res;

    // multiplier operands
    assign mul_a = ctrl.mul_k ? smh_pkg::k_const(ctrl.wa) : rd_a;

    always_comb
    begin
        case (ctrl.bsel)
            smh_pkg::BSEL_POP: mul_b = {57'd0, pop};
            smh_pkg::BSEL_REM: mul_b = {32'd0, rem_reg};
            smh_pkg::BSEL_LEN: mul_b = {32'd0, len_reg};
            default:           mul_b = rd_b;
        endcase
    end

    // byte count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load.start)
            begin
                rem_reg <= load.length;
            end
            else if (ctrl.we && ctrl.alu == smh_pkg::ALU_CHUNK
                     && ctrl.wsrc == smh_pkg::WSRC_ALU)
            begin
                rem_reg <= rem_next;
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load.start)
        begin
            len_reg <= load.length;
        end
        if (load.absorb)
        begin
            chunk_reg <= load.word;
        end
        if (ctrl.emit)
        begin
            first_reg  <= rd_a;
            second_reg <= rd_b;
        end
    end

    assign status.rem_nz    = |rem_reg;
    assign status.mul_done  = mul_done;
    assign status.out_stall = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign hash_first  = first_reg;
    assign hash_second = second_reg;

endmodule

[hw/rtl/smh_seq.sv]
module smh_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             launch_start,
    input  logic             launch_absorb,
    input  smh_pkg::status_t status,
    output smh_pkg::ctrl_t   ctrl,
    output logic             idle
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_WAIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    smh_pkg::upc_t       upc_reg;
    smh_pkg::upc_t       upc_next;
    smh_pkg::upc_t       upc_inc;
    smh_pkg::uword_t     uw;

    assign uw      = smh_pkg::ucode(upc_reg);
    assign upc_inc = smh_pkg::upc_t'(upc_reg + 1'b1);

    // step decode: each step reads operands, then executes; multiplies then wait for the product
    always_comb
    begin
        state_next     = state_reg;
        upc_next       = upc_reg;
        ctrl.we        = 1'b0;
        ctrl.wsrc      = smh_pkg::WSRC_ALU;
        ctrl.alu       = smh_pkg::ALU_ADD;
        ctrl.wa        = uw.wa;
        ctrl.ra        = uw.ra;
        ctrl.rb        = uw.rb;
        ctrl.mul_start = 1'b0;
        ctrl.mul_k     = (uw.op == smh_pkg::UOP_MULK);
        ctrl.bsel      = uw.bsel;
        ctrl.emit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (launch_start)
                begin
                    upc_next   = smh_pkg::START_PC;
                    state_next = S_READ;
                end
                else if (launch_absorb)
                begin
                    upc_next   = smh_pkg::ABSORB_PC;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (uw.op)
                    smh_pkg::UOP_ADD,
                    smh_pkg::UOP_XOR,
                    smh_pkg::UOP_CHUNK:
                    begin
                        ctrl.we    = 1'b1;
                        ctrl.alu   = (uw.op == smh_pkg::UOP_XOR)   ? smh_pkg::ALU_XOR :
                                     (uw.op == smh_pkg::UOP_CHUNK) ? smh_pkg::ALU_CHUNK :
                                                                     smh_pkg::ALU_ADD;
                        upc_next   = upc_inc;
                        state_next = S_READ;
                    end
                    smh_pkg::UOP_MUL,
                    smh_pkg::UOP_MULK:
                    begin
                        ctrl.mul_start = 1'b1;
                        state_next     = S_WAIT;
                    end
                    smh_pkg::UOP_BNZ:
                    begin
                        upc_next   = status.rem_nz ? uw.target : upc_inc;
                        state_next = S_READ;
                    end
                    smh_pkg::UOP_JMP:
                    begin
                        upc_next   = uw.target;
                        state_next = S_READ;
                    end
                    smh_pkg::UOP_EMIT:
                    begin
                        // hold while the previous result is still pending
                        if (!status.out_stall)
                        begin
                            ctrl.emit  = 1'b1;
                            upc_next   = upc_inc;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (status.mul_done)
                begin
                    ctrl.we    = 1'b1;
                    ctrl.wsrc  = smh_pkg::WSRC_MUL;
                    upc_next   = upc_inc;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            upc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

[hw/rtl/streaming_mix_hash_128.sv]
// Microcoded hash core: every add/xor step is an operand read then an execute; every
// 64-bit multiply runs on one shared 32x32 multiplier (three partial products).
// No item is taken until the sequencer is idle again; a start item for an empty message
// yields a result, as does the last chunk item; a held result stalls the sequencer.
// Reset clears the sequencer, the byte count and the result valid; the working words sit
// in an uncleared register file; a start seeds A to H and X; T and U are set before use.
module streaming_mix_hash_128 (
    input logic         clk,
    input logic         rst_n,
    smh_stream_if.sink   msg,
    smh_stream_if.source hash
);

    smh_pkg::ctrl_t   ctrl;
    smh_pkg::status_t status;
    smh_pkg::load_t   load;
    logic             idle;
    logic             transfer;

    // items are taken whenever the sequencer is idle; idle chunks are dropped
    assign msg.ready   = idle;
    assign transfer    = msg.valid && idle;
    assign load.start  = transfer && msg.data.start_req;
    assign load.absorb = transfer && !msg.data.start_req && status.rem_nz;
    assign load.length = msg.data.message_length;
    assign load.word   = msg.data.message_word;

    smh_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .launch_start  (load.start),
        .launch_absorb (load.absorb),
        .status        (status),
        .ctrl          (ctrl),
        .idle          (idle)
    );

    smh_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .ctrl        (ctrl),
        .status      (status),
        .out_ready   (hash.ready),
        .out_valid   (hash.valid),
        .hash_first  (hash.data.hash_first),
        .hash_second (hash.data.hash_second)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

    // Seed multipliers for the working words, applied to the message length
    localparam bit [63:0] SEED_A = 64'h5555555555555555;
    localparam bit [63:0] SEED_B = 64'hD0BE70F475039C26;
    localparam bit [63:0] SEED_C = 64'h0A28494D0470FBCF;
    localparam bit [63:0] SEED_D = 64'h2269E48CA777A798;
    localparam bit [63:0] SEED_E = 64'hAAAAAAAAAAAAAAAA;
    localparam bit [63:0] SEED_F = 64'hE697EB07151FA162;
    localparam bit [63:0] SEED_G = 64'h7ED6D2C445D9F5F6;
    localparam bit [63:0] SEED_H = 64'h47DF9C8E1A35F1BA;
    localparam bit [63:0] SEED_X = 64'h66A89CDDE262DA8D;

    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS  = 290;

    logic clk;
    logic rst_n;

    smh_stream_if #(.payload_t(smh_pkg::in_item_t))  msg_if ();
    smh_stream_if #(.payload_t(smh_pkg::out_item_t)) hash_if ();

    streaming_mix_hash_128 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .hash  (hash_if)
    );

    // Hash predictor plus the queue of hashes still owed by the block
    class mix_hash_checker;
        bit [63:0] ma, mb, mc, md, me, mf, mg, mh;
        bit [63:0] acc;
        bit [31:0] left_bytes;
        bit        open_msg;
        smh_pkg::out_item_t expected_hashes[$];
        int        errors;

        function void close_message();
            smh_pkg::out_item_t h;
            h.hash_first  = ((((((acc * mb) + md) * mf) + mh) * ma) + mc) * me + mg;
            h.hash_second = ((((((acc * mg) + me) * mc) + ma) * mh) + mf) * md + mb;
            open_msg = 1'b0;
            expected_hashes.push_back(h);
        endfunction

        function void absorb(bit [63:0] word);
            bit [63:0] x;
            bit [63:0] chunk;
            x = acc;
            if (left_bytes >= 32'd8) begin
                left_bytes -= 32'd8;
                chunk = word;
            end
            else begin
                left_bytes -= 32'd1;
                chunk = {56'b0, word[7:0]};
            end
            x = x + chunk;
            x = x + x * 64'($countones(x));

            // three add/xor mix chains
            ma += x;  mb ^= ma; mc += mb; md ^= mc; x += md;
            me ^= x;  mf += me; mg ^= mf; mh += mg;

            mc += x;  mg ^= mc; me += mg; ma ^= me; x += ma;
            mb ^= x;  md += mb; mh ^= md; mf += mh;

            mh += x;  mg ^= mh; mf += mg; me ^= mf; x += me;
            md ^= x;  mc += md; mb ^= mc; ma += mb;

            x = x + x * {32'b0, left_bytes};
            acc = x;
        endfunction

        function void note_item(smh_pkg::in_item_t it);
            bit [63:0] len;
            if (it.start_req) begin
                len = {32'b0, it.message_length};
                ma = SEED_A * len; mb = SEED_B * len; mc = SEED_C * len;
                md = SEED_D * len; me = SEED_E * len; mf = SEED_F * len;
                mg = SEED_G * len; mh = SEED_H * len;
                acc = SEED_X * len;
                left_bytes = it.message_length;
                if (left_bytes == 32'd0)
                    close_message();
                else
                    open_msg = 1'b1;
            end
            else if (open_msg && left_bytes != 32'd0) begin
                absorb(it.message_word);
                if (left_bytes == 32'd0)
                    close_message();
            end
        endfunction

        function void check_hash(smh_pkg::out_item_t got);
            smh_pkg::out_item_t want;
            if (expected_hashes.size() == 0) begin
                $error("hash result with none expected: hash_first %h hash_second %h",
                       got.hash_first, got.hash_second);
                errors++;
                return;
            end
            want = expected_hashes.pop_front();
            if (got.hash_first !== want.hash_first) begin
                $error("hash_first: expected %h, actual %h", want.hash_first, got.hash_first);
                errors++;
            end
            if (got.hash_second !== want.hash_second) begin
                $error("hash_second: expected %h, actual %h",
                       want.hash_second, got.hash_second);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hashes.size();
        endfunction
    endclass

    mix_hash_checker book;

    int send_mode;
    int recv_mode;
    bit hold_req;
    int counted_items;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && msg_if.valid && msg_if.ready)
            book.note_item(msg_if.data);
        if (rst_n && hash_if.valid && hash_if.ready)
            book.check_hash(hash_if.data);
    end

    // Idle length: mode 0 none, 1 mostly short, 2 frequent and longer
    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1) begin
            if (r < 60) return 0;
            if (r < 90) return $urandom_range(1, 3);
            return $urandom_range(10, 100);
        end
        if (r < 30) return 0;
        if (r < 80) return $urandom_range(1, 8);
        return $urandom_range(20, 120);
    endfunction

    function automatic bit [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One transfer on the message channel; called at a rising edge
    task automatic send_item(bit start, bit [31:0] len, bit [63:0] word, bit counted);
        smh_pkg::in_item_t it;
        int       gap;
        it.start_req      = start;
        it.message_length = len;
        it.message_word   = word;
        gap = pick_gap(send_mode);
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.data  <= it;
        do @(posedge clk); while (!msg_if.ready);
        if (counted)
            counted_items++;
    endtask

    // Start item followed by exactly the chunks the length calls for
    task automatic send_message(bit [31:0] len);
        bit [31:0] rest;
        send_item(1'b1, len, rand_word(), 1'b1);
        rest = len;
        while (rest != 0) begin
            send_item(1'b0, $urandom, rand_word(), 1'b1);
            rest -= (rest >= 32'd8) ? 32'd8 : 32'd1;
        end
    endtask

    // Sender holds off until every owed hash has come out
    task automatic drain();
        msg_if.valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    task automatic random_message();
        int        r;
        int        n;
        bit [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // possibly cut-off message, dropped by the next start if unfinished
            len = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 40);
            send_item(1'b1, len, rand_word(), 1'b1);
            n = $urandom_range(0, 4);
            repeat (n) send_item(1'b0, $urandom, rand_word(), 1'b1);
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 50)      len = $urandom_range(0, 15);
            else if (r < 90) len = $urandom_range(16, 40);
            else             len = $urandom_range(41, 80);
            send_message(len);
            // stray chunks while idle
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(1'b0, $urandom, rand_word(), 1'b0);
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        hash_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hash_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = pick_gap(recv_mode);
            if (stall > 0) begin
                hash_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hash_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        int target;
        book = new();
        send_mode = 1;
        recv_mode = 1;
        hold_req = 1'b0;
        counted_items = 0;
        msg_if.valid <= 1'b0;
        msg_if.data  <= '0;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // chunk with nothing open is ignored
        send_item(1'b0, 32'hFFFF_FFFF, '1, 1'b0);
        // empty message
        send_item(1'b1, 32'd0, '1, 1'b1);
        // longest length, abandoned by a restart
        send_item(1'b1, 32'hFFFF_FFFF, '0, 1'b1);
        send_item(1'b0, 32'd0, '1, 1'b1);
        send_item(1'b0, 32'd0, '0, 1'b1);
        send_item(1'b1, 32'd9, '1, 1'b1);
        send_item(1'b0, 32'd0, 64'h0123_4567_89AB_CDEF, 1'b1);
        // short tail: upper bits must not count
        send_item(1'b0, 32'd0, 64'hFFFF_FFFF_FFFF_FF00, 1'b1);
        send_item(1'b0, 32'd0, '1, 1'b0);
        send_item(1'b1, 32'd1, '0, 1'b1);
        send_item(1'b0, 32'd0, '1, 1'b1);
        send_item(1'b1, 32'd8, '0, 1'b1);
        send_item(1'b0, 32'd0, '1, 1'b1);
        send_item(1'b1, 32'd16, '1, 1'b1);
        send_item(1'b0, 32'd0, 64'h8000_0000_0000_0000, 1'b1);
        send_item(1'b0, 32'd0, 64'h1, 1'b1);
        // start right after start, then an all-tail message
        send_item(1'b1, 32'd5, '0, 1'b1);
        send_item(1'b1, 32'd0, '0, 1'b1);
        send_item(1'b1, 32'd3, '1, 1'b1);
        send_item(1'b0, 32'd0, 64'hA5, 1'b1);
        send_item(1'b0, 32'd0, 64'hFFFF_FFFF_FFFF_FF5A, 1'b1);
        send_item(1'b0, 32'd0, '0, 1'b1);
        drain();

        // random phases with different idling on each side
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_mode = 0; recv_mode = 0; end
                1:       begin send_mode = 1; recv_mode = 1; end
                2:       begin send_mode = 2; recv_mode = 1; end
                default: begin send_mode = 1; recv_mode = 2; end
            endcase
            if (p == 2) begin
                // back-pressure: hashes pile up while short messages keep coming
                hold_req = 1'b1;
                repeat (6) send_message($urandom_range(0, 2));
            end
            target = counted_items + PHASE_ITEMS;
            while (counted_items < target)
                random_message();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hw/rtl/smh_pkg.sv
hw/rtl/smh_stream_if.sv
hw/rtl/smh_ram.sv
hw/rtl/smh_mul.sv
hw/rtl/smh_datapath.sv
hw/rtl/smh_seq.sv
hw/rtl/streaming_mix_hash_128.sv
dv/tb.sv
